@@ src/hkc_pkg.sv @@
// Shared types and constants for the Hermite keyframe curve engine.
`default_nettype none

package hkc_pkg;

    localparam logic [1:0] OPC_APPEND = 2'd0;
    localparam logic [1:0] OPC_SMOOTH = 2'd1;
    localparam logic [1:0] OPC_EVAL   = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    // Divider widths: |dv| * 2^16 needs 49 bits, a doubled time span needs 34.
    localparam int DIV_NW = 49;
    localparam int DIV_DW = 34;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] point_time;
        logic signed [31:0] key_value;
        logic signed [31:0] in_slope;
        logic signed [31:0] out_slope;
    } hkc_in_t;

    typedef struct packed {
        logic signed [31:0] curve_value;
        logic [1:0]         status;
    } hkc_out_t;

    typedef struct packed {
        logic signed [31:0] ktime;
        logic signed [31:0] kval;
        logic signed [31:0] kin;
        logic signed [31:0] kout;
    } key_t;

    localparam int KEY_W = $bits(key_t);

    typedef enum logic [4:0] {
        OP_NONE,
        OP_APPEND,
        OP_RES_OK,
        OP_RES_EMPTY,
        OP_RD_FIRST,
        OP_CK_FIRST,
        OP_RD_LAST,
        OP_CK_LAST,
        OP_RD_IDX,
        OP_CK_IDX,
        OP_DIV_EVAL,
        OP_MUL_SS,
        OP_MUL_S2S,
        OP_COEF,
        OP_MUL_AV0,
        OP_MUL_CV1,
        OP_MUL_BOUT,
        OP_MUL_PDL,
        OP_MUL_PDH,
        OP_MUL_DIN,
        OP_RES_EVAL,
        OP_SM_RD0,
        OP_SM_CK0,
        OP_SM_RDN,
        OP_SM_CKN,
        OP_SM_CLR,
        OP_SM_DIVR,
        OP_SM_DIVL,
        OP_SM_ACC,
        OP_SM_WR
    } hkc_op_t;

    typedef struct packed {
        logic    load;
        hkc_op_t op;
    } hkc_cmd_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic       empty;
        logic       full;
        logic       few;
        logic       clamp_lo;
        logic       clamp_hi;
        logic       found;
        logic       first;
        logic       last;
        logic       more;
        logic       div_done;
    } hkc_stat_t;

endpackage

`default_nettype wire

@@ src/hkc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module hkc_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 64
) (
    input  wire logic                         clk,
    input  wire logic                         we,
    input  wire logic [$clog2(DEPTH)-1:0]     waddr,
    input  wire logic [WIDTH-1:0]             wdata,
    input  wire logic [$clog2(DEPTH)-1:0]     raddr,
    output logic      [WIDTH-1:0]             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ src/hkc_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none

module hkc_div
    import hkc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DIV_NW-1:0] num,
    input  wire logic [DIV_DW-1:0] den,
    output logic      [DIV_NW-1:0] quo,
    output logic                   done
);

    localparam int ITW = $clog2(DIV_NW + 1);

    logic [DIV_DW:0]   rem_reg;
    logic [DIV_NW-1:0] quo_reg;
    logic [DIV_DW-1:0] den_reg;
    logic [ITW-1:0]    it_reg;
    logic              run_reg;
    logic              done_reg;

    logic [DIV_DW:0]   trial;
    logic              ge;
    logic [DIV_DW:0]   rem_next;

    always_comb
    begin
        trial    = {rem_reg[DIV_DW-1:0], quo_reg[DIV_NW-1]};
        ge       = (trial >= {1'b0, den_reg});
        rem_next = ge ? (trial - {1'b0, den_reg}) : trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            it_reg   <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                it_reg  <= ITW'(DIV_NW);
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                it_reg <= it_reg - 1'b1;
                if (it_reg == ITW'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (run_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DIV_NW-2:0], ge};
        end
    end

    assign quo  = quo_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

@@ src/hkc_dp.sv @@
// Datapath: key table, scan and window registers, divider, multiplier, accumulator.
`default_nettype none

module hkc_dp
    import hkc_pkg::*;
#(
    parameter int MAX_KEYS = 64
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire hkc_in_t   item,
    input  wire hkc_cmd_t  cmd,
    output hkc_stat_t      stat,
    output hkc_out_t       result
);

    localparam int AW = $clog2(MAX_KEYS);
    localparam int CW = $clog2(MAX_KEYS + 1);

    hkc_in_t            in_reg;
    logic [CW-1:0]      cnt_reg;
    logic [CW-1:0]      idx_reg;
    key_t               k0_reg, k1_reg, sp_reg, sc_reg, sn_reg;
    logic [31:0]        dt_reg;
    logic               neg_reg, zero_reg;
    logic [16:0]        s_reg, s2_reg;
    logic signed [17:0] ca_reg, cb_reg, cc_reg, cd_reg;
    logic signed [35:0] p_reg;
    logic signed [53:0] prod_reg;
    logic signed [71:0] acc_reg;
    logic signed [50:0] msum_reg;
    hkc_out_t           res_reg;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [KEY_W-1:0]   ram_wdata, ram_rdata;
    key_t               rd_key;

    logic [CW-1:0]      cnt_m1, idx_p1;
    logic [CW:0]        idx_p2;
    logic               is_first, is_last, inner, full;
    logic signed [31:0] t;

    logic signed [32:0] dv;
    logic signed [33:0] dtd;
    logic [32:0]        dv_abs;
    logic [33:0]        dt_abs;
    logic               div_start;
    logic [DIV_NW-1:0]  div_q;
    logic               div_done;
    logic signed [49:0] q_signed;

    logic signed [35:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [71:0] prod_ext, prod_sh, acc_fin;
    logic [16:0]        s3_new;
    logic signed [19:0] e_s, e_s2, e_s3;
    logic signed [19:0] co_a, co_b, co_c, co_d;
    logic signed [31:0] m_sat, ev_sat;

    function automatic logic signed [31:0] sat32(input logic signed [50:0] x);
        logic signed [31:0] r;
        if (x > 51'sd2147483647)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (x < -51'sd2147483648)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = x[31:0];
        end
        return r;
    endfunction

    hkc_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_KEYS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    hkc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   ({dv_abs, 16'b0}),
        .den   (dt_abs),
        .quo   (div_q),
        .done  (div_done)
    );

    assign rd_key   = key_t'(ram_rdata);
    assign t        = in_reg.point_time;
    assign cnt_m1   = cnt_reg - 1'b1;
    assign idx_p1   = idx_reg + 1'b1;
    assign idx_p2   = {1'b0, idx_reg} + (CW+1)'(2);
    assign is_first = (idx_reg == '0);
    assign is_last  = (idx_reg == cnt_m1);
    assign inner    = !is_first && !is_last;
    assign full     = (cnt_reg == CW'(MAX_KEYS));

    always_comb
    begin
        stat.opcode   = in_reg.opcode;
        stat.empty    = (cnt_reg == '0);
        stat.full     = full;
        stat.few      = (cnt_reg < CW'(2));
        stat.clamp_lo = (t <= rd_key.ktime);
        stat.clamp_hi = (t >= rd_key.ktime);
        stat.found    = (rd_key.ktime > t);
        stat.first    = is_first;
        stat.last     = is_last;
        stat.more     = (idx_p2 < {1'b0, cnt_reg});
        stat.div_done = div_done;
    end

    // Key table ports.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = cnt_reg[AW-1:0];
        ram_wdata = {in_reg.point_time, in_reg.key_value, in_reg.in_slope, in_reg.out_slope};
        case (cmd.op)
            OP_APPEND:
            begin
                ram_we = !full;
            end
            OP_SM_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg[AW-1:0];
                ram_wdata = {sc_reg.ktime, sc_reg.kval, m_sat, m_sat};
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
        case (cmd.op)
            OP_RD_FIRST, OP_SM_RD0: ram_raddr = '0;
            OP_RD_LAST:             ram_raddr = cnt_m1[AW-1:0];
            OP_SM_RDN:              ram_raddr = idx_p1[AW-1:0];
            default:                ram_raddr = idx_reg[AW-1:0];
        endcase
    end

    // Divider operands: value difference over time difference, signs split off.
    always_comb
    begin
        case (cmd.op)
            OP_SM_DIVR:
            begin
                dv  = {sn_reg.kval[31], sn_reg.kval} - {sc_reg.kval[31], sc_reg.kval};
                dtd = {{2{sn_reg.ktime[31]}}, sn_reg.ktime}
                    - {{2{sc_reg.ktime[31]}}, sc_reg.ktime};
            end
            OP_SM_DIVL:
            begin
                dv  = {sc_reg.kval[31], sc_reg.kval} - {sp_reg.kval[31], sp_reg.kval};
                dtd = {{2{sc_reg.ktime[31]}}, sc_reg.ktime}
                    - {{2{sp_reg.ktime[31]}}, sp_reg.ktime};
            end
            default:
            begin
                dv  = {t[31], t} - {k0_reg.ktime[31], k0_reg.ktime};
                dtd = {{2{k1_reg.ktime[31]}}, k1_reg.ktime}
                    - {{2{k0_reg.ktime[31]}}, k0_reg.ktime};
            end
        endcase
        // Inner keys average two half-differences: double each span.
        if ((cmd.op == OP_SM_DIVR || cmd.op == OP_SM_DIVL) && inner)
        begin
            dtd = dtd <<< 1;
        end
        dv_abs    = dv[32] ? 33'(-dv) : 33'(dv);
        dt_abs    = dtd[33] ? 34'(-dtd) : 34'(dtd);
        div_start = (cmd.op == OP_DIV_EVAL) || (cmd.op == OP_SM_DIVR)
                 || (cmd.op == OP_SM_DIVL);
        if (zero_reg)
        begin
            q_signed = '0;
        end
        else if (neg_reg)
        begin
            q_signed = -$signed({1'b0, div_q});
        end
        else
        begin
            q_signed = $signed({1'b0, div_q});
        end
    end

    // Multiplier operand selection and Hermite coefficients.
    always_comb
    begin
        s3_new = prod_reg[32:16];
        e_s    = $signed({3'b0, s_reg});
        e_s2   = $signed({3'b0, s2_reg});
        e_s3   = $signed({3'b0, s3_new});
        co_a   = (e_s3 <<< 1) - (e_s2 <<< 1) - e_s2 + 20'sd65536;
        co_b   = e_s3 - (e_s2 <<< 1) + e_s;
        co_c   = (e_s2 <<< 1) + e_s2 - (e_s3 <<< 1);
        co_d   = e_s3 - e_s2;
        case (cmd.op)
            OP_MUL_SS:
            begin
                mul_a = $signed({19'b0, div_q[16:0]});
                mul_b = $signed({1'b0, div_q[16:0]});
            end
            OP_MUL_S2S:
            begin
                mul_a = $signed({19'b0, prod_reg[32:16]});
                mul_b = $signed({1'b0, s_reg});
            end
            OP_MUL_AV0:
            begin
                mul_a = 36'(k0_reg.kval);
                mul_b = ca_reg;
            end
            OP_MUL_CV1:
            begin
                mul_a = 36'(k1_reg.kval);
                mul_b = cc_reg;
            end
            OP_MUL_BOUT:
            begin
                mul_a = 36'(k0_reg.kout);
                mul_b = cb_reg;
            end
            OP_MUL_PDL:
            begin
                mul_a = $signed(prod_reg[51:16]);
                mul_b = $signed({2'b0, dt_reg[15:0]});
            end
            OP_MUL_PDH:
            begin
                mul_a = p_reg;
                mul_b = $signed({2'b0, dt_reg[31:16]});
            end
            OP_MUL_DIN:
            begin
                mul_a = 36'(k1_reg.kin);
                mul_b = cd_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_ext = 72'(prod_reg);
        prod_sh  = {{2{prod_reg[53]}}, prod_reg, 16'b0};
        acc_fin  = acc_reg + prod_sh;
        ev_sat   = sat32(51'($signed(acc_fin[71:32])));
        m_sat    = sat32(msum_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            case (cmd.op)
                OP_APPEND:
                begin
                    if (!full)
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                OP_CK_LAST:
                begin
                    idx_reg <= CW'(1);
                end
                OP_CK_IDX:
                begin
                    if (!stat.found)
                    begin
                        idx_reg <= idx_p1;
                    end
                end
                OP_SM_CK0:
                begin
                    idx_reg <= '0;
                end
                OP_SM_WR:
                begin
                    idx_reg <= idx_p1;
                end
                default:
                begin
                    idx_reg <= idx_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_reg <= item;
        end
        if (div_start)
        begin
            neg_reg  <= dv[32] ^ dtd[33];
            zero_reg <= (dtd == '0);
        end
        case (cmd.op)
            OP_APPEND:
            begin
                res_reg.curve_value <= '0;
                res_reg.status      <= full ? STAT_FULL : STAT_OK;
            end
            OP_RES_OK, OP_SM_WR:
            begin
                res_reg.curve_value <= '0;
                res_reg.status      <= STAT_OK;
            end
            OP_RES_EMPTY:
            begin
                res_reg.curve_value <= '0;
                res_reg.status      <= STAT_EMPTY;
            end
            OP_CK_FIRST:
            begin
                k0_reg <= rd_key;
                if (stat.clamp_lo)
                begin
                    res_reg.curve_value <= rd_key.kval;
                    res_reg.status      <= STAT_OK;
                end
            end
            OP_CK_LAST:
            begin
                if (stat.clamp_hi)
                begin
                    res_reg.curve_value <= rd_key.kval;
                    res_reg.status      <= STAT_OK;
                end
            end
            OP_CK_IDX:
            begin
                // The left key of the segment is the last one not later than the query.
                if (stat.found)
                begin
                    k1_reg <= rd_key;
                end
                else
                begin
                    k0_reg <= rd_key;
                end
            end
            OP_DIV_EVAL:
            begin
                dt_reg <= dtd[31:0];
            end
            OP_MUL_SS:
            begin
                s_reg    <= div_q[16:0];
                prod_reg <= mul_a * mul_b;
            end
            OP_MUL_S2S:
            begin
                s2_reg   <= prod_reg[32:16];
                prod_reg <= mul_a * mul_b;
            end
            OP_COEF:
            begin
                ca_reg  <= co_a[17:0];
                cb_reg  <= co_b[17:0];
                cc_reg  <= co_c[17:0];
                cd_reg  <= co_d[17:0];
                acc_reg <= '0;
            end
            OP_MUL_AV0:
            begin
                prod_reg <= mul_a * mul_b;
            end
            OP_MUL_CV1, OP_MUL_BOUT, OP_MUL_PDH:
            begin
                acc_reg  <= acc_reg + prod_ext;
                prod_reg <= mul_a * mul_b;
            end
            OP_MUL_PDL:
            begin
                p_reg    <= $signed(prod_reg[51:16]);
                prod_reg <= mul_a * mul_b;
            end
            OP_MUL_DIN:
            begin
                acc_reg  <= acc_fin;
                prod_reg <= mul_a * mul_b;
            end
            OP_RES_EVAL:
            begin
                res_reg.curve_value <= ev_sat;
                res_reg.status      <= STAT_OK;
            end
            OP_SM_CK0:
            begin
                sc_reg <= rd_key;
            end
            OP_SM_CKN:
            begin
                sn_reg <= rd_key;
            end
            OP_SM_CLR:
            begin
                msum_reg <= '0;
            end
            OP_SM_ACC:
            begin
                msum_reg <= msum_reg + 51'(q_signed);
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
        if (cmd.op == OP_SM_WR)
        begin
            sp_reg <= sc_reg;
            sc_reg <= sn_reg;
        end
    end

    assign result = res_reg;

endmodule

`default_nettype wire

@@ src/hkc_ctrl.sv @@
// Controller state machine that sequences the datapath for each item.
`default_nettype none

module hkc_ctrl
    import hkc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire hkc_stat_t stat,
    output hkc_cmd_t       cmd,
    output logic           busy,
    output logic           done
);

    typedef enum logic [5:0] {
        S_IDLE, S_DISP, S_APPEND, S_FIN_OK, S_FIN_EMPTY,
        S_EV_RD0, S_EV_CK0, S_EV_RDL, S_EV_CKL, S_EV_RDI, S_EV_CKI,
        S_EV_DIV, S_EV_DWAIT, S_EV_SS, S_EV_S2S, S_EV_COEF, S_EV_AV0,
        S_EV_CV1, S_EV_BOUT, S_EV_PDL, S_EV_PDH, S_EV_DIN, S_EV_QDL,
        S_EV_QDH, S_EV_FIN,
        S_SM_RD0, S_SM_CK0, S_SM_RDN, S_SM_CKN, S_SM_STEP,
        S_SM_DIVR, S_SM_WAITR, S_SM_ACCR, S_SM_DIVL, S_SM_WAITL, S_SM_ACCL, S_SM_WR
    } state_t;

    state_t state_reg;
    logic   busy_reg;
    logic   done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        busy_reg  <= 1'b1;
                        state_reg <= S_DISP;
                    end
                end
                S_DISP:
                begin
                    unique case (stat.opcode)
                        OPC_APPEND: state_reg <= S_APPEND;
                        OPC_SMOOTH: state_reg <= stat.few ? S_FIN_OK : S_SM_RD0;
                        OPC_EVAL:   state_reg <= stat.empty ? S_FIN_EMPTY : S_EV_RD0;
                        default:    state_reg <= S_FIN_OK;
                    endcase
                end
                S_APPEND, S_FIN_OK, S_FIN_EMPTY, S_EV_FIN:
                begin
                    state_reg <= S_IDLE;
                    busy_reg  <= 1'b0;
                    done_reg  <= 1'b1;
                end
                S_EV_RD0: state_reg <= S_EV_CK0;
                S_EV_CK0:
                begin
                    if (stat.clamp_lo)
                    begin
                        state_reg <= S_IDLE;
                        busy_reg  <= 1'b0;
                        done_reg  <= 1'b1;
                    end
                    else
                    begin
                        state_reg <= S_EV_RDL;
                    end
                end
                S_EV_RDL: state_reg <= S_EV_CKL;
                S_EV_CKL:
                begin
                    if (stat.clamp_hi)
                    begin
                        state_reg <= S_IDLE;
                        busy_reg  <= 1'b0;
                        done_reg  <= 1'b1;
                    end
                    else
                    begin
                        state_reg <= S_EV_RDI;
                    end
                end
                S_EV_RDI: state_reg <= S_EV_CKI;
                S_EV_CKI: state_reg <= stat.found ? S_EV_DIV : S_EV_RDI;
                S_EV_DIV: state_reg <= S_EV_DWAIT;
                S_EV_DWAIT:
                begin
                    if (stat.div_done)
                    begin
                        state_reg <= S_EV_SS;
                    end
                end
                S_EV_SS:   state_reg <= S_EV_S2S;
                S_EV_S2S:  state_reg <= S_EV_COEF;
                S_EV_COEF: state_reg <= S_EV_AV0;
                S_EV_AV0:  state_reg <= S_EV_CV1;
                S_EV_CV1:  state_reg <= S_EV_BOUT;
                S_EV_BOUT: state_reg <= S_EV_PDL;
                S_EV_PDL:  state_reg <= S_EV_PDH;
                S_EV_PDH:  state_reg <= S_EV_DIN;
                S_EV_DIN:  state_reg <= S_EV_QDL;
                S_EV_QDL:  state_reg <= S_EV_QDH;
                S_EV_QDH:  state_reg <= S_EV_FIN;
                S_SM_RD0:  state_reg <= S_SM_CK0;
                S_SM_CK0:  state_reg <= S_SM_RDN;
                S_SM_RDN:  state_reg <= S_SM_CKN;
                S_SM_CKN:  state_reg <= S_SM_STEP;
                S_SM_STEP: state_reg <= stat.last ? S_SM_DIVL : S_SM_DIVR;
                S_SM_DIVR: state_reg <= S_SM_WAITR;
                S_SM_WAITR:
                begin
                    if (stat.div_done)
                    begin
                        state_reg <= S_SM_ACCR;
                    end
                end
                S_SM_ACCR: state_reg <= stat.first ? S_SM_WR : S_SM_DIVL;
                S_SM_DIVL: state_reg <= S_SM_WAITL;
                S_SM_WAITL:
                begin
                    if (stat.div_done)
                    begin
                        state_reg <= S_SM_ACCL;
                    end
                end
                S_SM_ACCL: state_reg <= S_SM_WR;
                S_SM_WR:
                begin
                    if (stat.last)
                    begin
                        state_reg <= S_IDLE;
                        busy_reg  <= 1'b0;
                        done_reg  <= 1'b1;
                    end
                    else if (stat.more)
                    begin
                        state_reg <= S_SM_RDN;
                    end
                    else
                    begin
                        state_reg <= S_SM_STEP;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_comb
    begin
        cmd.load = start && !busy_reg;
        unique case (state_reg)
            S_APPEND:    cmd.op = OP_APPEND;
            S_FIN_OK:    cmd.op = OP_RES_OK;
            S_FIN_EMPTY: cmd.op = OP_RES_EMPTY;
            S_EV_RD0:    cmd.op = OP_RD_FIRST;
            S_EV_CK0:    cmd.op = OP_CK_FIRST;
            S_EV_RDL:    cmd.op = OP_RD_LAST;
            S_EV_CKL:    cmd.op = OP_CK_LAST;
            S_EV_RDI:    cmd.op = OP_RD_IDX;
            S_EV_CKI:    cmd.op = OP_CK_IDX;
            S_EV_DIV:    cmd.op = OP_DIV_EVAL;
            S_EV_SS:     cmd.op = OP_MUL_SS;
            S_EV_S2S:    cmd.op = OP_MUL_S2S;
            S_EV_COEF:   cmd.op = OP_COEF;
            S_EV_AV0:    cmd.op = OP_MUL_AV0;
            S_EV_CV1:    cmd.op = OP_MUL_CV1;
            S_EV_BOUT:   cmd.op = OP_MUL_BOUT;
            S_EV_PDL, S_EV_QDL: cmd.op = OP_MUL_PDL;
            S_EV_PDH, S_EV_QDH: cmd.op = OP_MUL_PDH;
            S_EV_DIN:    cmd.op = OP_MUL_DIN;
            S_EV_FIN:    cmd.op = OP_RES_EVAL;
            S_SM_RD0:    cmd.op = OP_SM_RD0;
            S_SM_CK0:    cmd.op = OP_SM_CK0;
            S_SM_RDN:    cmd.op = OP_SM_RDN;
            S_SM_CKN:    cmd.op = OP_SM_CKN;
            S_SM_STEP:   cmd.op = OP_SM_CLR;
            S_SM_DIVR:   cmd.op = OP_SM_DIVR;
            S_SM_DIVL:   cmd.op = OP_SM_DIVL;
            S_SM_ACCR, S_SM_ACCL: cmd.op = OP_SM_ACC;
            S_SM_WR:     cmd.op = OP_SM_WR;
            default:     cmd.op = OP_NONE;
        endcase
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

@@ src/hermite_keyframe_curve.sv @@
// Top level of the cubic Hermite keyframe curve engine.
//
//  Channel   Signals                 Handshake
//  -------   ---------------------   -----------------------------------------
//  command   start, busy, item       item taken at a clock edge with start && !busy
//  result    done, result            result valid for the single cycle done is high
//
// Append and an unknown opcode pass through dispatch and one finishing state to the result strobe.
// Evaluate time grows with K, the keys scanned; the key table's single read
// port and the bit-serial divider are what set it.
// Smooth runs two divider passes for each inner key.
// Reset clears the key count, so the table is empty; no clearing pass runs.
// busy is high from acceptance until the result strobe; the receiver cannot stall.
`default_nettype none

module hermite_keyframe_curve
    import hkc_pkg::*;
#(
    parameter int MAX_KEYS = 64
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire hkc_in_t item,
    output logic         busy,
    output logic         done,
    output hkc_out_t     result
);

    hkc_cmd_t  cmd;
    hkc_stat_t stat;

    hkc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    hkc_dp #(
        .MAX_KEYS (MAX_KEYS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .stat   (stat),
        .result (result)
    );

endmodule

`default_nettype wire

@@ src/hkc_chk.sv @@
// Port-level checks on the command and result channels, bound to the top level.
`default_nettype none

module hkc_chk
    import hkc_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     start,
    input wire logic     busy,
    input wire logic     done,
    input wire hkc_out_t result
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after an item was accepted");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while still busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe lasted more than one cycle");

    a_busy_ends_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy fell without a result");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == STAT_EMPTY) |-> (result.curve_value == '0))
        else $error("empty-table result carries a nonzero value");

endmodule

bind hermite_keyframe_curve hkc_chk u_chk (.*);

`default_nettype wire

@@ tb/sv/tb_hermite_keyframe_curve.sv @@
// Self-checking testbench for the Hermite keyframe curve engine.
`default_nettype none

module tb_hermite_keyframe_curve;
    import hkc_pkg::*;

    localparam int KEY_SLOTS  = 64;
    localparam int ITEM_GOAL  = 1150;
    localparam int IDLE_LIMIT = 60000;
    localparam int SMOOTH_CAP = 24;
    localparam logic [1:0] OPC_UNUSED = 2'd3;

    logic     clk;
    logic     rst_n;
    logic     start;
    hkc_in_t  item;
    logic     busy;
    logic     done;
    hkc_out_t result;

    // Predictor state: a copy of the key table and its fill level.
    key_t     model_keys [KEY_SLOTS];
    int       key_total;
    hkc_out_t expected_results [$];

    int errors;
    int items_sent;
    int evals_sent;
    int smooths_sent;
    int full_appends;
    int results_seen;
    int idle_cycles;
    longint last_key_time;

    hermite_keyframe_curve #(.MAX_KEYS(KEY_SLOTS)) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic signed [31:0] clip32(longint x);
        if (x > longint'(32'sh7FFF_FFFF))
            return 32'sh7FFF_FFFF;
        if (x < -longint'(64'sh8000_0000))
            return 32'sh8000_0000;
        return x[31:0];
    endfunction

    // Finite-difference slope; a zero span gives a flat tangent.
    function automatic longint diff_slope(longint dv, longint dt);
        if (dt == 0)
            return 0;
        return (dv * 65536) / dt;
    endfunction

    function automatic void smooth_keys();
        longint v, t, m;
        int n;
        n = key_total;
        if (n < 2)
            return;
        for (int i = 0; i < n; i++)
        begin
            v = longint'(model_keys[i].kval);
            t = longint'(model_keys[i].ktime);
            if (i == 0)
                m = diff_slope(longint'(model_keys[1].kval) - v,
                               longint'(model_keys[1].ktime) - t);
            else if (i == n - 1)
                m = diff_slope(v - longint'(model_keys[i-1].kval),
                               t - longint'(model_keys[i-1].ktime));
            else
                m = diff_slope(longint'(model_keys[i+1].kval) - v,
                               2 * (longint'(model_keys[i+1].ktime) - t))
                  + diff_slope(v - longint'(model_keys[i-1].kval),
                               2 * (t - longint'(model_keys[i-1].ktime)));
            model_keys[i].kin  = clip32(m);
            model_keys[i].kout = clip32(m);
        end
    endfunction

    function automatic logic signed [31:0] curve_at(longint t);
        longint t0, dt, u, s, s2, s3, a, b, c, d, acc;
        int hi;
        hi = key_total - 1;
        if (t <= longint'(model_keys[0].ktime))
            return model_keys[0].kval;
        if (t >= longint'(model_keys[key_total-1].ktime))
            return model_keys[key_total-1].kval;
        for (int i = 1; i < key_total; i++)
        begin
            if (longint'(model_keys[i].ktime) > t)
            begin
                hi = i;
                break;
            end
        end
        t0 = longint'(model_keys[hi-1].ktime);
        dt = longint'(model_keys[hi].ktime) - t0;
        u  = t - t0;
        if (dt <= 0 || u < 0)
            return model_keys[hi-1].kval;
        s  = (u * 65536) / dt;
        s2 = (s * s) >>> 16;
        s3 = (s2 * s) >>> 16;
        a  = 2 * s3 - 3 * s2 + 65536;
        b  = s3 - 2 * s2 + s;
        c  = 3 * s2 - 2 * s3;
        d  = s3 - s2;
        acc = a * longint'(model_keys[hi-1].kval) + c * longint'(model_keys[hi].kval)
            + ((b * longint'(model_keys[hi-1].kout)) >>> 16) * dt
            + ((d * longint'(model_keys[hi].kin)) >>> 16) * dt;
        return clip32(acc >>> 32);
    endfunction

    // Applies one accepted item to the predictor and returns its result.
    function automatic hkc_out_t predict_result(hkc_in_t it);
        hkc_out_t r;
        r.curve_value = '0;
        r.status      = STAT_OK;
        case (it.opcode)
            OPC_APPEND:
            begin
                if (key_total >= KEY_SLOTS)
                    r.status = STAT_FULL;
                else
                begin
                    model_keys[key_total].ktime = it.point_time;
                    model_keys[key_total].kval  = it.key_value;
                    model_keys[key_total].kin   = it.in_slope;
                    model_keys[key_total].kout  = it.out_slope;
                    key_total++;
                end
            end
            OPC_SMOOTH:
                smooth_keys();
            OPC_EVAL:
            begin
                if (key_total == 0)
                    r.status = STAT_EMPTY;
                else
                    r.curve_value = curve_at(longint'(it.point_time));
            end
            default:
                ;
        endcase
        return r;
    endfunction

    task automatic send_item(logic [1:0] opc, logic [31:0] t, logic [31:0] v,
                             logic [31:0] si, logic [31:0] so);
        int gap;
        logic was_full;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
        @(negedge clk);
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        item.opcode     = opc;
        item.point_time = t;
        item.key_value  = v;
        item.in_slope   = si;
        item.out_slope  = so;
        start = 1'b1;
        do
            @(posedge clk);
        while (busy);
        was_full = (key_total >= KEY_SLOTS);
        expected_results = {expected_results, predict_result(item)};
        items_sent++;
        if (opc == OPC_EVAL)
            evals_sent++;
        if (opc == OPC_SMOOTH)
            smooths_sent++;
        if (opc == OPC_APPEND && was_full)
            full_appends++;
    endtask

    task automatic test_empty_table();
        send_item(OPC_EVAL, 32'h0, 32'h0, 32'h0, 32'h0);
        send_item(OPC_EVAL, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OPC_SMOOTH, 32'h0, 32'h0, 32'h0, 32'h0);
        send_item(OPC_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_single_key();
        send_item(OPC_APPEND, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(OPC_SMOOTH, 32'h0, 32'h0, 32'h0, 32'h0);
        send_item(OPC_EVAL, 32'h8000_0000, 32'h0, 32'h0, 32'h0);
        send_item(OPC_EVAL, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0);
    endtask

    // Extreme values and slopes, a repeated key time and a tight segment.
    task automatic test_directed_segments();
        send_item(OPC_APPEND, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_item(OPC_APPEND, 32'h0, 32'h0, 32'h0, 32'h0);
        send_item(OPC_APPEND, 32'h0001_0000, 32'h7FFF_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(OPC_EVAL, 32'h0000_8000, 32'h0, 32'h0, 32'h0);
        send_item(OPC_EVAL, 32'h0000_0001, 32'h0, 32'h0, 32'h0);
        send_item(OPC_EVAL, 32'h0000_FFFF, 32'h0, 32'h0, 32'h0);
        send_item(OPC_EVAL, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);
        send_item(OPC_EVAL, 32'hC000_0000, 32'h0, 32'h0, 32'h0);
        send_item(OPC_SMOOTH, 32'h0, 32'h0, 32'h0, 32'h0);
        send_item(OPC_EVAL, 32'h0000_8000, 32'h0, 32'h0, 32'h0);
        send_item(OPC_EVAL, 32'h0001_0000, 32'h0, 32'h0, 32'h0);
        last_key_time = 64'sh1_0000;
    endtask

    task automatic test_random_traffic();
        int r, i;
        longint t, lo, hi;
        logic [31:0] v, si, so;
        while (items_sent < ITEM_GOAL)
        begin
            r  = $urandom_range(0, 99);
            v  = $urandom;
            si = ($urandom_range(0, 1) != 0) ? $urandom
               : 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            so = ($urandom_range(0, 1) != 0) ? $urandom
               : 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            if (key_total < KEY_SLOTS && r < 35)
            begin
                // Mostly ascending keys; a few land anywhere to break the order.
                t = last_key_time + $urandom_range(1, 1 << 22);
                if ($urandom_range(0, 9) == 0 || t > longint'(32'sh7FFF_FFFF))
                    t = longint'($signed($urandom));
                else if ($urandom_range(0, 19) == 0)
                    t = last_key_time;
                last_key_time = t;
                send_item(OPC_APPEND, t[31:0], v, si, so);
            end
            else if (r < 38 && smooths_sent < SMOOTH_CAP)
                send_item(OPC_SMOOTH, $urandom, $urandom, $urandom, $urandom);
            else if (r < 41)
                send_item(($urandom_range(0, 1) != 0) ? OPC_APPEND : OPC_UNUSED,
                          $urandom, v, si, so);
            else
            begin
                r = $urandom_range(0, 9);
                if (key_total >= 2 && r < 6)
                begin
                    i  = $urandom_range(0, key_total - 2);
                    lo = longint'(model_keys[i].ktime);
                    hi = longint'(model_keys[i+1].ktime);
                    if (hi > lo)
                        t = lo + longint'({$urandom, $urandom} % 64'(hi - lo));
                    else
                        t = lo;
                end
                else if (key_total >= 1 && r < 8)
                    t = longint'(model_keys[$urandom_range(0, key_total - 1)].ktime)
                      + $signed($urandom_range(0, 2)) - 1;
                else
                    t = longint'($signed($urandom));
                send_item(OPC_EVAL, t[31:0], $urandom, $urandom, $urandom);
            end
        end
    endtask

    // Every strobed result is matched against the oldest prediction.
    always @(posedge clk)
    begin
        hkc_out_t want;
        if (rst_n && done)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result curve_value=%h status=%0d",
                         $time, result.curve_value, result.status);
            end
            else
            begin
                want = expected_results.pop_front();
                if (result.curve_value !== want.curve_value)
                begin
                    errors++;
                    $display("%0t: curve_value mismatch expected %h actual %h",
                             $time, want.curve_value, result.curve_value);
                end
                if (result.status !== want.status)
                begin
                    errors++;
                    $display("%0t: status mismatch expected %0d actual %0d",
                             $time, want.status, result.status);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        item  = '0;
        errors = 0;
        items_sent = 0;
        evals_sent = 0;
        smooths_sent = 0;
        full_appends = 0;
        results_seen = 0;
        idle_cycles = 0;
        key_total = 0;
        last_key_time = 0;
        foreach (model_keys[k])
            model_keys[k] = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        test_empty_table();
        test_single_key();
        test_directed_segments();
        test_random_traffic();

        @(negedge clk);
        start = 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d items (%0d evaluates, %0d smooths, %0d appends on a full table).",
                 items_sent, evals_sent, smooths_sent, full_appends);
        $display("Checked %0d results with %0d keys stored, %0d mismatches.",
                 results_seen, key_total, errors);
        if (errors == 0 && expected_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
